// ===== rtl/bis_pkg.sv =====
// Package for the bilinear image sampler: command codes, register indexes,
// configuration port widths and the accumulator control struct.
// No dependencies.
package bis_pkg;

  localparam int FIELD_W     = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 9;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// ===== rtl/bis_pixel_ram.sv =====
// Single-port pixel memory with registered read data.
// One write or one read per cycle. No package dependency.
module bis_pixel_ram #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bis_mac.sv =====
// Shared weight-multiply-accumulate unit: weight = gx*gy, then pixel*weight,
// then accumulate. Three register stages. Uses bis_pkg::mac_ctrl_t.
module bis_mac #(
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 8,
  localparam int WGT_W     = FRAC_BITS + 1,
  localparam int ACC_W     = PIXEL_BITS + 2 * FRAC_BITS + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bis_pkg::mac_ctrl_t    ctrl_i,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  input  logic [WGT_W-1:0]      gx_i,
  input  logic [WGT_W-1:0]      gy_i,
  output logic [ACC_W-1:0]      acc_o
);

  localparam int WW = 2 * WGT_W;
  localparam int PW = PIXEL_BITS + WW;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (2 * FRAC_BITS - 1);

  logic                  v_a_q;
  logic                  v_b_q;
  logic [PIXEL_BITS-1:0] pix_a_q;
  logic [WW-1:0]         wgt_a_q;
  logic [PW-1:0]         prod_b_q;
  logic [ACC_W-1:0]      acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
    end else begin
      v_a_q <= ctrl_i.valid;
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      pix_a_q <= pixel_i;
      wgt_a_q <= WW'(gx_i) * WW'(gy_i);
    end
    if (v_a_q) begin
      prod_b_q <= PW'(pix_a_q) * PW'(wgt_a_q);
    end
    if (ctrl_i.clear) begin
      acc_q <= ROUND;
    end else if (v_b_q) begin
      acc_q <= acc_q + ACC_W'(prod_b_q);
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/bilinear_image_sampler_unit.sv =====
// Bilinear image sampler top level: configuration registers, sequencer,
// address generation. Uses bis_pkg, bis_pixel_ram and bis_mac.
//
// Input channel (in_valid_i / in_stall_o): a write transaction (command 0)
// stores one pixel and gives no result. A sample
// transaction (command 1) reads the four neighbours, one per cycle from the
// single-port pixel memory, weights them in the shared multiply-accumulate
// unit and gives one result. An in-range sample goes from acceptance
// through the four memory reads and the unit pipeline drain to a load of
// the result register; an out-of-range sample goes straight to the load.
// The next transaction is accepted once the sequencer is back in idle;
// writes are taken at one per cycle while it is idle.
// Output channel (out_valid_o / out_stall_i): one result register. While the
// receiver stalls, the result holds and new writes are still taken; a
// finished sample waits for the register to free.
// Configuration (cfg_valid_i / cfg_ready_o): always ready; write only while
// idle. Reset sets width and height to 256 and empties the result register;
// pixel memory is not cleared and must be written before it is sampled.
module bilinear_image_sampler_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [bis_pkg::FIELD_W-1:0]       pixel_address_i,
  input  logic [bis_pkg::FIELD_W-1:0]       pixel_value_i,
  input  logic [bis_pkg::FIELD_W-1:0]       coord_x_i,
  input  logic [bis_pkg::FIELD_W-1:0]       coord_y_i,
  input  logic                              query_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bis_pkg::FIELD_W-1:0]       intensity_o,
  output logic                              out_of_range_o,
  output logic                              result_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bis_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH + 1);
  localparam int YW     = $clog2(MAX_HEIGHT + 1);
  localparam int IW     = bis_pkg::FIELD_W - FRAC_BITS;
  localparam int PROD_W = IW + XW;
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int ACC_W  = PIXEL_BITS + 2 * FRAC_BITS + 1;
  localparam logic [WGT_W-1:0] ONE_FIX = WGT_W'(1) << FRAC_BITS;
  localparam logic [1:0] READ_LAST  = 2'd3;
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic [1:0] step_q;
  logic       oor_q;
  logic       last_q;
  logic       out_valid_q;
  logic [bis_pkg::FIELD_W-1:0] intensity_q;
  logic       out_oor_q;
  logic       out_last_q;

  logic [bis_pkg::CFG_DATA_W-1:0] width_q;
  logic [bis_pkg::CFG_DATA_W-1:0] height_q;
  logic [XW-1:0] w_sat;
  logic [YW-1:0] h_sat;

  logic [IW-1:0]        ix_in;
  logic [IW-1:0]        iy_in;
  logic [FRAC_BITS-1:0] fx_in;
  logic [FRAC_BITS-1:0] fy_in;
  logic                 x_oor;
  logic                 y_oor;
  logic [PROD_W-1:0]    row_prod;

  logic [ADDR_W-1:0]    base0_q;
  logic [ADDR_W-1:0]    base1_q;
  logic [ADDR_W-1:0]    row_step_q;
  logic [ADDR_W-1:0]    col0_q;
  logic [ADDR_W-1:0]    col1_q;
  logic [FRAC_BITS-1:0] fx_q;
  logic [FRAC_BITS-1:0] fy_q;

  logic                 in_accept;
  logic                 sample_accept;
  logic                 ram_en;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [PIXEL_BITS-1:0] ram_rdata;
  logic [WGT_W-1:0]     gx_sel;
  logic [WGT_W-1:0]     gy_sel;
  logic                 rd_v_q;
  logic [WGT_W-1:0]     rd_gx_q;
  logic [WGT_W-1:0]     rd_gy_q;
  bis_pkg::mac_ctrl_t   mac_ctrl;
  logic [ACC_W-1:0]     acc;
  logic [PIXEL_BITS-1:0] pix_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bis_pkg::DIM_RESET;
      height_q <= bis_pkg::DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bis_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        bis_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_sat = XW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_sat = XW'(MAX_WIDTH);
    end else begin
      w_sat = XW'(width_q);
    end
    if (height_q == '0) begin
      h_sat = YW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_sat = YW'(MAX_HEIGHT);
    end else begin
      h_sat = YW'(height_q);
    end
  end

  assign ix_in = coord_x_i[bis_pkg::FIELD_W-1:FRAC_BITS];
  assign iy_in = coord_y_i[bis_pkg::FIELD_W-1:FRAC_BITS];
  assign fx_in = coord_x_i[FRAC_BITS-1:0];
  assign fy_in = coord_y_i[FRAC_BITS-1:0];

  assign x_oor = (32'(ix_in) >= 32'(w_sat)) ||
                 ((32'(ix_in) == 32'(w_sat) - 32'd1) && (fx_in != '0));
  assign y_oor = (32'(iy_in) >= 32'(h_sat)) ||
                 ((32'(iy_in) == 32'(h_sat) - 32'd1) && (fy_in != '0));

  assign row_prod = PROD_W'(iy_in) * PROD_W'(w_sat);

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign sample_accept = in_accept && (command_i == bis_pkg::CMD_SAMPLE);

  always_ff @(posedge clk_i) begin
    if (sample_accept) begin
      base0_q    <= ADDR_W'(row_prod);
      row_step_q <= (fy_in != '0) ? ADDR_W'(w_sat) : '0;
      col0_q     <= ADDR_W'(ix_in);
      col1_q     <= ADDR_W'(ix_in) + ((fx_in != '0) ? ADDR_W'(1) : '0);
      fx_q       <= fx_in;
      fy_q       <= fy_in;
    end
    if (state_q == ST_READ && step_q == 2'd0) begin
      base1_q <= base0_q + row_step_q;
    end
  end

  always_comb begin
    case (step_q)
      2'd0:    rd_addr = base0_q + col0_q;
      2'd1:    rd_addr = base0_q + col1_q;
      2'd2:    rd_addr = base1_q + col0_q;
      default: rd_addr = base1_q + col1_q;
    endcase
  end

  assign gx_sel = step_q[0] ? WGT_W'(fx_q) : ONE_FIX - WGT_W'(fx_q);
  assign gy_sel = step_q[1] ? WGT_W'(fy_q) : ONE_FIX - WGT_W'(fy_q);

  assign ram_we   = in_accept && (command_i == bis_pkg::CMD_WRITE) &&
                    (32'(pixel_address_i) < 32'(DEPTH));
  assign ram_en   = ram_we || (state_q == ST_READ);
  assign ram_addr = (state_q == ST_READ) ? rd_addr : ADDR_W'(pixel_address_i);

  bis_pixel_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (PIXEL_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (PIXEL_BITS'(pixel_value_i)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= (state_q == ST_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_gx_q <= gx_sel;
      rd_gy_q <= gy_sel;
    end
  end

  assign mac_ctrl.clear = sample_accept;
  assign mac_ctrl.valid = rd_v_q;

  bis_mac #(
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .pixel_i (ram_rdata),
    .gx_i    (rd_gx_q),
    .gy_i    (rd_gy_q),
    .acc_o   (acc)
  );

  assign pix_res = acc[2*FRAC_BITS +: PIXEL_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 2'd0;
      oor_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      intensity_q <= '0;
      out_oor_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (sample_accept) begin
            last_q <= query_last_i;
            step_q <= 2'd0;
            if (x_oor || y_oor) begin
              oor_q   <= 1'b1;
              state_q <= ST_FINISH;
            end else begin
              oor_q   <= 1'b0;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (step_q == READ_LAST) begin
            step_q  <= 2'd0;
            state_q <= ST_DRAIN;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        ST_DRAIN: begin
          if (step_q == DRAIN_LAST) begin
            step_q  <= 2'd0;
            state_q <= ST_FINISH;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            intensity_q <= oor_q ? '0 : bis_pkg::FIELD_W'(pix_res);
            out_oor_q   <= oor_q;
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign intensity_o    = intensity_q;
  assign out_of_range_o = out_oor_q;
  assign result_last_o  = out_last_q;

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (intensity_o == '0))
    else $error("out-of-range result with nonzero intensity");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !(out_valid_q && out_stall_i))
      |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished sample not loaded into result register");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("pixel write while sample in progress");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.clear |-> !rd_v_q)
    else $error("accumulator cleared while reads in flight");

endmodule

// ===== bench/bilinear_image_sampler_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bilinear_image_sampler_unit: pixel loads, bilinear samples and
// image size registers, checked against an interpolator kept inside the bench.
// Depends on bis_pkg and the bilinear_image_sampler_unit RTL.
module bilinear_image_sampler_unit_test;

  localparam int FIELD_W = bis_pkg::FIELD_W;
  localparam int CFG_INDEX_W = bis_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W = bis_pkg::CFG_DATA_W;
  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int PIX_W = 16;
  localparam int FRAC_W = 8;
  localparam int STORE_DEPTH = MAX_W * MAX_H;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam longint unsigned UNIT = 64'd1 << FRAC_W;

  typedef struct {
    logic               cmd;
    logic [FIELD_W-1:0] addr;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] cx;
    logic [FIELD_W-1:0] cy;
    logic               last;
  } pix_txn_t;

  typedef struct {
    logic [FIELD_W-1:0] intensity;
    logic               oor;
    logic               last;
  } pix_result_t;

  class bilinear_tracker;
    logic [PIX_W-1:0] pixel_mem [STORE_DEPTH];
    bit pixel_set [STORE_DEPTH];
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pix_result_t expected_intensities [$];
    int unsigned failures;
    int unsigned checked;
    int unsigned oor_seen;
    int unsigned loads;

    function new();
      width_reg = bis_pkg::DIM_RESET;
      height_reg = bis_pkg::DIM_RESET;
      failures = 0;
      checked = 0;
      oor_seen = 0;
      loads = 0;
    endfunction

    function int unsigned span(logic [CFG_DATA_W-1:0] r, int unsigned lim);
      if (r == 0) return 1;
      if (32'(r) > lim) return lim;
      return 32'(r);
    endfunction

    function int unsigned cols();
      return span(width_reg, MAX_W);
    endfunction

    function int unsigned rows();
      return span(height_reg, MAX_H);
    endfunction

    function int unsigned pending();
      return expected_intensities.size();
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx,
                          logic [CFG_DATA_W-1:0] val);
      case (idx)
        bis_pkg::REG_IMAGE_WIDTH: width_reg = val;
        bis_pkg::REG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function bit outside(logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy);
      int unsigned w, h, ix, iy;
      logic [FRAC_W-1:0] fx, fy;
      w = cols();
      h = rows();
      ix = 32'(cx[FIELD_W-1:FRAC_W]);
      iy = 32'(cy[FIELD_W-1:FRAC_W]);
      fx = cx[FRAC_W-1:0];
      fy = cy[FRAC_W-1:0];
      return ix >= w || (ix == w - 1 && fx != 0) || iy >= h || (iy == h - 1 && fy != 0);
    endfunction

    function void note_transaction(pix_txn_t t);
      pix_result_t r;
      int unsigned w, ix, iy, ux, uy;
      longint unsigned fx, fy, p00, p10, p01, p11, acc;
      if (t.cmd == bis_pkg::CMD_WRITE) begin
        pixel_mem[t.addr] = t.value;
        pixel_set[t.addr] = 1'b1;
        loads++;
        return;
      end
      r.last = t.last;
      if (outside(t.cx, t.cy)) begin
        r.intensity = '0;
        r.oor = 1'b1;
        expected_intensities.push_back(r);
        return;
      end
      w = cols();
      ix = 32'(t.cx[FIELD_W-1:FRAC_W]);
      iy = 32'(t.cy[FIELD_W-1:FRAC_W]);
      fx = 64'(t.cx[FRAC_W-1:0]);
      fy = 64'(t.cy[FRAC_W-1:0]);
      ux = (fx != 0) ? ix + 1 : ix;
      uy = (fy != 0) ? iy + 1 : iy;
      p00 = 64'(pixel_mem[ADDR_W'(iy * w + ix)]);
      p10 = 64'(pixel_mem[ADDR_W'(iy * w + ux)]);
      p01 = 64'(pixel_mem[ADDR_W'(uy * w + ix)]);
      p11 = 64'(pixel_mem[ADDR_W'(uy * w + ux)]);
      acc = p00 * (UNIT - fx) * (UNIT - fy) + p10 * fx * (UNIT - fy)
          + p01 * (UNIT - fx) * fy + p11 * fx * fy;
      acc = (acc + (64'd1 << (2 * FRAC_W - 1))) >> (2 * FRAC_W);
      r.intensity = acc[FIELD_W-1:0];
      r.oor = 1'b0;
      expected_intensities.push_back(r);
    endfunction

    function void check_result(logic [FIELD_W-1:0] got_val, logic got_oor, logic got_last);
      pix_result_t want;
      if (expected_intensities.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected result intensity=%h oor=%b last=%b",
                   got_val, got_oor, got_last);
        return;
      end
      want = expected_intensities.pop_front();
      checked++;
      if (want.oor) oor_seen++;
      if (got_val !== want.intensity || got_oor !== want.oor || got_last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: expected intensity=%h oor=%b last=%b, got %h oor=%b last=%b",
                   want.intensity, want.oor, want.last, got_val, got_oor, got_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = bis_pkg::CMD_WRITE;
  logic [FIELD_W-1:0] pixel_address = '0;
  logic [FIELD_W-1:0] pixel_value = '0;
  logic [FIELD_W-1:0] coord_x = '0;
  logic [FIELD_W-1:0] coord_y = '0;
  logic query_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FIELD_W-1:0] intensity;
  logic out_of_range;
  logic result_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = bis_pkg::REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bilinear_tracker sb;
  bit quiet = 1'b0;
  int unsigned sent = 0;
  int unsigned sizes_seen = 0;

  bilinear_image_sampler_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .PIXEL_BITS(PIX_W),
    .FRAC_BITS (FRAC_W)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .pixel_address_i(pixel_address),
    .pixel_value_i  (pixel_value),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .query_last_i   (query_last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .intensity_o    (intensity),
    .out_of_range_o (out_of_range),
    .result_last_o  (result_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 18);
  endfunction

  always @(posedge clk) begin
    out_stall <= take_break();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(intensity, out_of_range, result_last);
  end

  task automatic push_item(pix_txn_t t);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= t.cmd;
    pixel_address <= t.addr;
    pixel_value <= t.value;
    coord_x <= t.cx;
    coord_y <= t.cy;
    query_last <= t.last;
    do @(posedge clk); while (in_stall);
    sb.note_transaction(t);
    sent++;
  endtask

  task automatic push_write(logic [FIELD_W-1:0] addr, logic [FIELD_W-1:0] value, logic last);
    pix_txn_t t;
    t = '{cmd: bis_pkg::CMD_WRITE, addr: addr, value: value, cx: FIELD_W'($urandom),
          cy: FIELD_W'($urandom), last: last};
    push_item(t);
  endtask

  function automatic logic [FIELD_W-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return FIELD_W'($urandom);
  endfunction

  // for an in-range sample, load any neighbour not yet written, then issue the sample
  task automatic probe_at(logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy, logic last);
    int unsigned w, ix, iy, ux, uy;
    int unsigned spots [4];
    pix_txn_t t;
    if (!sb.outside(cx, cy)) begin
      w = sb.cols();
      ix = 32'(cx[FIELD_W-1:FRAC_W]);
      iy = 32'(cy[FIELD_W-1:FRAC_W]);
      ux = (cx[FRAC_W-1:0] != 0) ? ix + 1 : ix;
      uy = (cy[FRAC_W-1:0] != 0) ? iy + 1 : iy;
      spots = '{iy * w + ix, iy * w + ux, uy * w + ix, uy * w + ux};
      foreach (spots[k])
        if (!sb.pixel_set[ADDR_W'(spots[k])])
          push_write(spots[k][FIELD_W-1:0], rand_pixel(), 1'($urandom_range(1)));
    end
    t = '{cmd: bis_pkg::CMD_SAMPLE, addr: FIELD_W'($urandom), value: FIELD_W'($urandom),
          cx: cx, cy: cy, last: last};
    push_item(t);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    for (int n = 0; n < 4000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_dims(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= bis_pkg::REG_IMAGE_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(bis_pkg::REG_IMAGE_WIDTH, w);
    cfg_index <= bis_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(bis_pkg::REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    sizes_seen++;
  endtask

  task automatic random_phase(int unsigned quota);
    int unsigned stop, w, h, ix, iy, fx, fy, pick, wx, wy;
    stop = sent + quota;
    while (sent < stop) begin
      w = sb.cols();
      h = sb.rows();
      pick = $urandom_range(99);
      if (pick < 15) begin
        if ($urandom_range(1) != 0)
          push_write(FIELD_W'($urandom), rand_pixel(), 1'($urandom_range(1)));
        else push_write(FIELD_W'($urandom_range(w * h - 1)), rand_pixel(), 1'b0);
      end else if (pick < 25) begin
        probe_at(FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom_range(1)));
      end else begin
        wx = ($urandom_range(3) == 0 || w < 12) ? w : 12;
        wy = ($urandom_range(3) == 0 || h < 12) ? h : 12;
        ix = $urandom_range(wx - 1);
        iy = $urandom_range(wy - 1);
        fx = $urandom_range(255);
        fy = $urandom_range(255);
        if (pick < 35) begin
          if ($urandom_range(1) != 0) begin
            ix = w - 1;
            fx = ($urandom_range(2) == 0) ? $urandom_range(1, 255) : 0;
          end else begin
            iy = h - 1;
            fy = ($urandom_range(2) == 0) ? $urandom_range(1, 255) : 0;
          end
        end else begin
          if (ix == w - 1) fx = 0;
          if (iy == h - 1) fy = 0;
        end
        probe_at({8'(ix), 8'(fx)}, {8'(iy), 8'(fy)}, 1'($urandom_range(1)));
      end
    end
    settle();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] widths [9];
    logic [CFG_DATA_W-1:0] heights [9];
    sb = new();
    widths = '{9'd256, 9'd0, 9'd1, 9'd511, 9'd2, 9'($urandom_range(1, 256)), 9'd256, 9'd300,
               9'($urandom_range(1, 256))};
    heights = '{9'd256, 9'd0, 9'd256, 9'd1, 9'd3, 9'($urandom_range(1, 256)), 9'd511, 9'd0,
                9'($urandom_range(1, 256))};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_write(16'h0000, 16'hFFFF, 1'b1);
    push_write(16'h0001, 16'h0000, 1'b0);
    push_write(16'h0100, 16'h0000, 1'b0);
    push_write(16'h0101, 16'hFFFF, 1'b0);
    push_write(16'hFFFF, 16'hFFFF, 1'b0);
    push_write(16'hFFFE, 16'h1234, 1'b1);
    push_write(16'hFEFF, 16'h8000, 1'b0);
    push_write(16'hFEFE, 16'h0001, 1'b0);
    probe_at(16'h0000, 16'h0000, 1'b0);
    probe_at(16'h0080, 16'h0080, 1'b0);
    probe_at(16'h0001, 16'h0000, 1'b1);
    probe_at(16'h0100, 16'h0000, 1'b0);
    probe_at(16'hFF00, 16'hFF00, 1'b0);
    probe_at(16'hFE80, 16'hFF00, 1'b1);
    probe_at(16'hFEFF, 16'hFEFF, 1'b0);
    probe_at(16'hFF80, 16'hFF00, 1'b0);
    probe_at(16'h0000, 16'hFF01, 1'b1);
    probe_at(16'hFFFF, 16'hFFFF, 1'b1);
    settle();

    foreach (widths[i]) begin
      set_dims(widths[i], heights[i]);
      quiet = (i == 5);
      random_phase(95);
    end
    quiet = 1'b0;

    $display("Covered %0d samples (%0d out of range) and %0d pixel loads over %0d image sizes.",
             sb.checked, sb.oor_seen, sb.loads, sizes_seen);
    $display("Mismatches: %0d, results still outstanding: %0d.", sb.failures, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("bilinear_image_sampler_unit verification clean");
    end else begin
      $display("bilinear_image_sampler_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bilinear_image_sampler_unit verification failed");
    $finish;
  end

endmodule
